[rtl/core/aspr_pkg.sv]
package aspr_pkg;

  localparam int unsigned ADDR_W      = 13;
  localparam int unsigned ATTR_AW     = 10;
  localparam int unsigned BITMAP_BYTES = 6144;
  localparam int unsigned ATTR_BYTES  = 768;
  localparam logic [ADDR_W-1:0] ATTR_BASE  = 13'h1800;
  localparam logic [ADDR_W-1:0] SCREEN_END = 13'd6912;

  localparam logic [7:0] LAST_COL     = 8'd255;
  localparam logic [7:0] LAST_ROW     = 8'd191;
  localparam logic [7:0] DIM_LEVEL    = 8'd215;
  localparam logic [7:0] BRIGHT_LEVEL = 8'd255;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CMD_WR_BMP  = 2'd0,
    CMD_WR_ATTR = 2'd1,
    CMD_RENDER  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ADDR_W-1:0]  bmp_addr;
    logic [ATTR_AW-1:0] attr_addr;
    logic [7:0]         data;
    logic [7:0]         x;
    logic [7:0]         y;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [FIFO_AW:0]   count;
  } fifo_status_t;

endpackage

[rtl/core/aspr_if.sv]
interface aspr_in_if import aspr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] address;
  logic [7:0]        data;

  modport source (output valid, output op, output address, output data, input ready);
  modport sink (input valid, input op, input address, input data, output ready);
endinterface

interface aspr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_end;

  modport source (output valid, output pixel_x, output pixel_y, output red, output green,
                  output blue, output frame_end, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input red, input green,
                input blue, input frame_end, output ready);
endinterface

[rtl/core/aspr_fifo.sv]
module aspr_fifo import aspr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  cmd_t         push_cmd,
  input  logic         pop,
  output cmd_t         head,
  output fifo_status_t status
);

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign status.count = count_r;
  assign status.full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign status.empty = (count_r == '0);

endmodule

[rtl/core/aspr_front.sv]
module aspr_front import aspr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  aspr_in_if.sink      in_ch,
  input  fifo_status_t fifo_st,
  output logic         push,
  output cmd_t         push_cmd
);

  logic [7:0] x_r;
  logic [7:0] y_r;
  logic       accept;
  logic       is_render;
  logic       last;

  assign in_ch.ready = !fifo_st.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_render   = (op_t'(in_ch.op) == OP_RENDER);
  assign last        = (x_r == LAST_COL) && (y_r == LAST_ROW);

  // writes past the attribute area are dropped here
  assign push = accept && (is_render || (in_ch.address < SCREEN_END));

  always_comb begin
    push_cmd.data      = in_ch.data;
    push_cmd.x         = x_r;
    push_cmd.y         = y_r;
    push_cmd.last      = last;
    if (is_render) begin
      push_cmd.kind      = CMD_RENDER;
      // interleaved third / scan line / char row layout, row bit 7 unused
      push_cmd.bmp_addr  = {1'b0, y_r[6], y_r[2:0], y_r[5:3], x_r[7:3]};
      push_cmd.attr_addr = {y_r[7:3], x_r[7:3]};
    end else begin
      push_cmd.kind      = (in_ch.address < ATTR_BASE) ? CMD_WR_BMP : CMD_WR_ATTR;
      push_cmd.bmp_addr  = in_ch.address;
      push_cmd.attr_addr = ATTR_AW'(in_ch.address - ATTR_BASE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else if (accept && is_render) begin
      x_r <= x_r + 1'b1;
      if (x_r == LAST_COL) begin
        y_r <= (y_r == LAST_ROW) ? '0 : y_r + 1'b1;
      end
    end
  end

endmodule

[rtl/core/aspr_back.sv]
module aspr_back import aspr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cmd_t         head,
  input  fifo_status_t fifo_st,
  output logic         pop,
  aspr_out_if.source   out_ch
);

  logic [7:0] bmp_mem  [BITMAP_BYTES];
  logic [7:0] attr_mem [ATTR_BYTES];

  logic       b_valid_r;
  logic [7:0] b_x_r;
  logic [7:0] b_y_r;
  logic       b_last_r;
  logic [7:0] bmp_q_r;
  logic [7:0] attr_q_r;

  logic       c_valid_r;
  logic [7:0] c_x_r;
  logic [7:0] c_y_r;
  logic [7:0] c_red_r;
  logic [7:0] c_green_r;
  logic [7:0] c_blue_r;
  logic       c_last_r;

  logic       c_free;
  logic       b_free;
  logic       pop_render;
  logic       lit;
  logic [2:0] colour;
  logic [7:0] level;

  assign c_free     = !c_valid_r || out_ch.ready;
  assign b_free     = !b_valid_r || c_free;
  assign pop        = !fifo_st.empty && ((head.kind != CMD_RENDER) || b_free);
  assign pop_render = pop && (head.kind == CMD_RENDER);

  always_ff @(posedge clk) begin
    if (pop && (head.kind == CMD_WR_BMP)) begin
      bmp_mem[head.bmp_addr] <= head.data;
    end
    if (pop_render) begin
      bmp_q_r <= bmp_mem[head.bmp_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head.kind == CMD_WR_ATTR)) begin
      attr_mem[head.attr_addr] <= head.data;
    end
    if (pop_render) begin
      attr_q_r <= attr_mem[head.attr_addr];
    end
  end

  // pixel bit msb first, ink on set bit, paper on clear bit
  assign lit    = bmp_q_r[~b_x_r[2:0]];
  assign colour = lit ? attr_q_r[2:0] : attr_q_r[5:3];
  assign level  = attr_q_r[6] ? BRIGHT_LEVEL : DIM_LEVEL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (c_free) begin
        c_valid_r <= b_valid_r;
      end
      if (pop_render) begin
        b_valid_r <= 1'b1;
      end else if (c_free) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_render) begin
      b_x_r    <= head.x;
      b_y_r    <= head.y;
      b_last_r <= head.last;
    end
    if (b_valid_r && c_free) begin
      c_x_r     <= b_x_r;
      c_y_r     <= b_y_r;
      c_last_r  <= b_last_r;
      c_red_r   <= colour[1] ? level : '0;
      c_green_r <= colour[2] ? level : '0;
      c_blue_r  <= colour[0] ? level : '0;
    end
  end

  assign out_ch.valid     = c_valid_r;
  assign out_ch.pixel_x   = c_x_r;
  assign out_ch.pixel_y   = c_y_r;
  assign out_ch.red       = c_red_r;
  assign out_ch.green     = c_green_r;
  assign out_ch.blue      = c_blue_r;
  assign out_ch.frame_end = c_last_r;

endmodule

[rtl/core/attribute_screen_pixel_renderer_unit.sv]
// a render beat passes the queue, the registered store reads and the output
//   register; throughput: one beat per cycle while out_ch keeps up, writes and
//   renders alike, set by one read port per store and the output register
// reset: synchronous active-low rst_n clears the raster position, queue and
//   pipeline valids; the screen stores are not cleared and no clearing pass runs
module attribute_screen_pixel_renderer_unit import aspr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  aspr_in_if.sink     in_ch,
  aspr_out_if.source  out_ch
);

  // front: raster counters, address formation, classification of beats
  // queue: four-entry command queue so front and back stall independently
  // back: screen stores, registered reads, colour and palette, output register
  fifo_status_t fifo_st;
  logic         push;
  cmd_t         push_cmd;
  logic         pop;
  cmd_t         head;

  aspr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .fifo_st  (fifo_st),
    .push     (push),
    .push_cmd (push_cmd)
  );

  aspr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (fifo_st)
  );

  aspr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .fifo_st (fifo_st),
    .pop     (pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && fifo_st.full))
    else $error("command queue overflow");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && fifo_st.empty))
    else $error("command queue underflow");

  // frame end only on the bottom-right pixel
  a_frame_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_end) |-> (out_ch.pixel_x == LAST_COL &&
                                             out_ch.pixel_y == LAST_ROW))
    else $error("frame end away from last pixel");

  // emitted rows stay inside the frame
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.pixel_y <= LAST_ROW))
    else $error("pixel row out of frame");
`endif

endmodule

[test/tb_top.sv]
module tb_top import aspr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // run sizing
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned RANDOM_BEATS  = 1100;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned SETTLE_CYCLES = 20;

  // one emitted pixel as seen on the result channel
  typedef struct {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;

  aspr_in_if  in_ch ();
  aspr_out_if out_ch ();

  attribute_screen_pixel_renderer_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // mirror of the screen memory, with a written flag per byte so that
  // no render ever touches a byte the block has not been given
  logic [7:0] screen_bitmap  [BITMAP_BYTES];
  logic [7:0] screen_attr    [ATTR_BYTES];
  bit         bitmap_written [BITMAP_BYTES];
  bit         attr_written   [ATTR_BYTES];

  // raster position of the next render beat
  logic [7:0] scan_x = 8'd0;
  logic [7:0] scan_y = 8'd0;

  pixel_t      pending_pixels [$];
  pixel_t      want;
  int unsigned errors = 0;
  int unsigned cycle_count;

  // idling control shared by sender and receiver
  bit          idle_on = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  // interleaved bitmap offset: row bit 6, then row bits 2:0, then row bits 5:3,
  // then the column byte; row bit 7 does not take part
  function automatic logic [12:0] bitmap_offset(logic [7:0] y, logic [4:0] col);
    return {1'b0, y[6], y[2:0], y[5:3], col};
  endfunction

  // one attribute byte per 8x8 cell
  function automatic logic [9:0] attr_index(logic [7:0] y, logic [4:0] col);
    return {y[7:3], col};
  endfunction

  // colour of one raster pixel from the mirrored screen
  function automatic pixel_t shade_pixel(logic [7:0] x, logic [7:0] y);
    logic [7:0] bits;
    logic [7:0] attr;
    logic [2:0] colour;
    logic [7:0] level;
    pixel_t     p;
    bits   = screen_bitmap[bitmap_offset(y, x[7:3])];
    attr   = screen_attr[attr_index(y, x[7:3])];
    // leftmost pixel is the msb, so the bit index is the inverted column phase
    colour = bits[~x[2:0]] ? attr[2:0] : attr[5:3];
    // bit 6 is bright, bit 7 (flash) plays no part
    level  = attr[6] ? BRIGHT_LEVEL : DIM_LEVEL;
    p.x         = x;
    p.y         = y;
    p.blue      = colour[0] ? level : 8'd0;
    p.red       = colour[1] ? level : 8'd0;
    p.green     = colour[2] ? level : 8'd0;
    p.frame_end = (x == LAST_COL) && (y == LAST_ROW);
    return p;
  endfunction

  // update the mirror for one accepted beat
  task automatic apply_beat(input op_t op, input logic [12:0] addr, input logic [7:0] data);
    pixel_t     p;
    logic [9:0] aoff;
    if (op == OP_WRITE) begin
      if (addr < BITMAP_BYTES) begin
        screen_bitmap[addr]  = data;
        bitmap_written[addr] = 1'b1;
      end else if (addr < SCREEN_END) begin
        aoff               = 10'(addr - ATTR_BASE);
        screen_attr[aoff]  = data;
        attr_written[aoff] = 1'b1;
      end
      // writes past the attribute area are dropped and give no pixel
    end else begin
      p = shade_pixel(scan_x, scan_y);
      pending_pixels.push_back(p);
      // raster wrap: end of row to next row, end of frame back to the origin
      if (scan_x == LAST_COL) begin
        scan_x = 8'd0;
        scan_y = (scan_y == LAST_ROW) ? 8'd0 : scan_y + 8'd1;
      end else begin
        scan_x = scan_x + 8'd1;
      end
    end
  endtask

  // mostly back to back, sometimes a short gap, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one beat and wait until it is taken; valid stays high after the
  // beat so the next one can follow without a bubble
  task automatic send_beat(input op_t op, input logic [12:0] addr, input logic [7:0] data);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.address <= addr;
    in_ch.data    <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_beat(op, addr, data);
  endtask

  // render the next pixel, loading its bitmap and attribute bytes first if
  // they were never written; address and data of a render carry junk
  task automatic render_next();
    logic [12:0] boff;
    logic [9:0]  aidx;
    boff = bitmap_offset(scan_y, scan_x[7:3]);
    aidx = attr_index(scan_y, scan_x[7:3]);
    if (!bitmap_written[boff]) send_beat(OP_WRITE, boff, 8'($urandom_range(0, 255)));
    if (!attr_written[aidx]) send_beat(OP_WRITE, ATTR_BASE + aidx, 8'($urandom_range(0, 255)));
    send_beat(OP_RENDER, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
  endtask

  // drop valid so nothing more is offered, then wait for every pixel
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // field extremes, ink and paper, dim and bright, flash, dropped writes,
  // junk fields on renders
  task automatic test_directed();
    int i;
    send_beat(OP_WRITE, 13'd0, 8'hA5);                  // row 0, column byte 0
    send_beat(OP_WRITE, 13'd1, 8'hFF);                  // row 0, column byte 1, all ink
    send_beat(OP_WRITE, ATTR_BASE, 8'h31);              // dim, ink blue, paper green+red
    send_beat(OP_WRITE, ATTR_BASE + 13'd1, 8'hC7);      // flash + bright, ink white
    send_beat(OP_WRITE, 13'd6143, 8'h00);               // last bitmap byte
    send_beat(OP_WRITE, 13'd6911, 8'hFF);               // last attribute byte
    send_beat(OP_WRITE, SCREEN_END, 8'hAA);             // first address past the screen
    send_beat(OP_WRITE, 13'h1FFF, 8'h55);               // top of the address range
    for (i = 0; i < 16; i++) begin
      send_beat(OP_RENDER, i[0] ? 13'h1FFF : 13'h0000, i[1] ? 8'hFF : 8'h00);
    end
  endtask

  // random writes across the whole address range mixed with renders,
  // in stretches with and without idling
  task automatic test_random_mix();
    int unsigned n;
    int unsigned r;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        render_next();
      end else if (r < 93) begin
        send_beat(OP_WRITE, 13'($urandom_range(0, 6911)), 8'($urandom_range(0, 255)));
      end else begin
        send_beat(OP_WRITE, 13'($urandom_range(6912, 8191)), 8'($urandom_range(0, 255)));
      end
    end
    idle_on = 1'b1;
  endtask

  // receiver holds off for a long stretch while renders keep coming, so the
  // pipeline and command queue fill and the input stalls
  task automatic test_output_hold();
    int i;
    idle_on = 1'b0;
    hold_requests++;
    for (i = 0; i < 40; i++) render_next();
    idle_on = 1'b1;
  endtask

  // sender goes quiet until every pixel is out, then starts again
  task automatic test_pause_until_drained();
    int i;
    for (i = 0; i < 20; i++) render_next();
    wait_drained();
    for (i = 0; i < 20; i++) render_next();
  endtask

  // run the raster to the end of the current row and across into the next
  // one; no idling to keep the run short
  task automatic test_row_wrap();
    logic [7:0] start;
    int i;
    idle_on = 1'b0;
    start = scan_y;
    while (scan_y == start) render_next();
    idle_on = 1'b1;
    for (i = 0; i < 12; i++) render_next();
  endtask

  // receiver: random stalls, plus the long hold when one is asked for
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 20) begin
        hold_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(9, 39);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] expected, logic [7:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expected, actual);
      errors++;
    end
  endfunction

  // compare every pixel beat with the oldest expected pixel
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel beat with none expected, actual x=%0d y=%0d", $time,
                 out_ch.pixel_x, out_ch.pixel_y);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", want.x, out_ch.pixel_x);
        check_field("pixel_y", want.y, out_ch.pixel_y);
        check_field("red", want.red, out_ch.red);
        check_field("green", want.green, out_ch.green);
        check_field("blue", want.blue, out_ch.blue);
        check_field("frame_end", {7'd0, want.frame_end}, {7'd0, out_ch.frame_end});
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("attribute_screen_pixel_renderer_unit regression: fail");
    $finish;
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_WRITE;
    in_ch.address = '0;
    in_ch.data    = '0;
    rst_n         = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mix();
    test_output_hold();
    test_pause_until_drained();
    test_row_wrap();

    // close the input, let the pipeline empty, then watch for strays
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("attribute_screen_pixel_renderer_unit regression: pass");
    end else begin
      $display("attribute_screen_pixel_renderer_unit regression: fail");
    end
    $finish;
  end

endmodule
